@@ sv/frustum_plane_aabb_cull_macros.svh @@
// Assertion macros shared by the frustum culling RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef FRUSTUM_PLANE_AABB_CULL_MACROS_SVH
`define FRUSTUM_PLANE_AABB_CULL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpac check failed");

// Next-cycle implication, disabled during reset.
`define FPAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpac check failed");

`endif

@@ sv/fpac_pkg.sv @@
// Shared constants, types and helper functions for the frustum culling block.
// No dependencies; imported by fpac_div and the top level.
package fpac_pkg;

    localparam int MAX_PLANES  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int ROW_W       = 4 * WORD_W;
    localparam int PLANE_AW    = $clog2(MAX_PLANES);
    localparam int MAT_ROWS    = 4;
    localparam int MAT_AW      = 2;
    localparam int CNT_W       = 5;
    localparam int SLOT_W      = 4;
    localparam int EXT_PLANES  = 6;
    localparam int DIV_W       = WORD_W + FRAC_BITS;
    localparam int LEN_W       = 32;
    localparam int SQ_W        = 64;
    localparam int ACC_W       = WORD_W + FRAC_BITS + 3;
    localparam int IN_DATA_W   = 328;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam logic [CNT_W-1:0] PLANE_COUNT_RST = CNT_W'(6);

    typedef enum logic [1:0] {
        MODE_LOAD_ROW,
        MODE_EXTRACT,
        MODE_WRITE_PLANE,
        MODE_TEST_BOX
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_ZERO_NORMAL,
        STAT_BAD_SLOT
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EX_RD,
        ST_EX_ROW,
        ST_EX_SQ,
        ST_EX_SQRT,
        ST_EX_DIV,
        ST_EX_DIVW,
        ST_EX_WR,
        ST_BX_RD,
        ST_BX_MUL,
        ST_BX_CMP,
        ST_DONE
    } state_t;

    // Matrix column used by each extracted plane (right, left, bottom, top, far, near)
    function automatic logic [1:0] ext_col(input logic [2:0] p);
        logic [1:0] c;
        case (p)
            3'd0, 3'd1: c = 2'd0;
            3'd2, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    // 1: row sum, 0: row difference
    function automatic logic ext_add(input logic [2:0] p);
        logic a;
        case (p)
            3'd1, 3'd2, 3'd5: a = 1'b1;
            default:          a = 1'b0;
        endcase
        return a;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_pm(
        input logic signed [WORD_W-1:0] a,
        input logic signed [WORD_W-1:0] b,
        input logic add);
        logic signed [WORD_W:0] s;
        logic signed [WORD_W-1:0] r;
        s = add ? (WORD_W+1)'(a) + (WORD_W+1)'(b) : (WORD_W+1)'(a) - (WORD_W+1)'(b);
        if (s[WORD_W] != s[WORD_W-1])
            r = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        else
            r = s[WORD_W-1:0];
        return r;
    endfunction

endpackage

@@ sv/fpac_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fpac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/fpac_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fpac_pkg for operand widths.
module fpac_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fpac_pkg::DIV_W-1:0]  dividend,
    input  logic [fpac_pkg::LEN_W-1:0]  divisor,
    output logic                        busy,
    output logic [fpac_pkg::DIV_W-1:0]  quotient
);
    import fpac_pkg::*;

    localparam int DCNT_W = $clog2(DIV_W + 1);

    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [LEN_W:0]    trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = LEN_W'(trial - {1'b0, divisor});
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[LEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/frustum_plane_aabb_cull.sv @@
// Frustum plane store and box culling top level.
// Depends on fpac_pkg, fpac_ram, fpac_div and frustum_plane_aabb_cull_macros.svh.
//
// Usage:
//   Input beats arrive on s_axis; tuser carries the item kind (load matrix
//   row, extract planes, write plane, test box) and tdata the slot, four
//   Q16.16 values and six box corner words. Every item returns exactly one
//   result beat on m_axis with the culled bit and a status code.
//   The block works on one item at a time. A box test walks at most
//   plane_count planes, capped at 16, stopping at the first plane that
//   culls; each plane is one plane-RAM read and then multiply steps on
//   the shared 32x32 multiplier. Plane extraction is dominated by the
//   32-step square root and four 48-step divisions per plane, six planes.
//   The user must write plane_count through cfg_we/cfg_wdata only while
//   the block is idle; the block itself does not enforce this.
//   Reset sets plane_count to 6; per-row valid bits make never-written
//   matrix rows and planes read as zero, so no clearing pass is needed.
//   A result held by a stalled receiver stays in the output register; the
//   next input beat is taken meanwhile, and its result waits until the
//   output register frees up.
`include "frustum_plane_aabb_cull_macros.svh"

module frustum_plane_aabb_cull (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[3:0], value_a, value_b, value_c, value_d, min_x, min_y, min_z,
    // max_x, max_y, max_z (32 bits each), zero fill
    input  logic [fpac_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [fpac_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // culled[0], status[2:1], zero fill
    output logic [fpac_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [fpac_pkg::CNT_W-1:0]      cfg_wdata
);
    import fpac_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        plane_count_reg;
    logic                    out_valid_reg;
    logic                    out_culled_reg;
    status_t                 out_status_reg;
    logic                    res_culled_reg;
    status_t                 res_status_reg;

    logic [MAT_ROWS-1:0]     mat_valid_reg;
    logic [MAX_PLANES-1:0]   plane_valid_reg;
    logic                    mat_rvalid_reg;
    logic                    plane_rvalid_reg;

    logic signed [WORD_W-1:0] corner_min_reg [3];
    logic signed [WORD_W-1:0] corner_max_reg [3];

    logic [2:0]              plane_idx_reg;
    logic [MAT_AW-1:0]       row_cnt_reg;
    logic [1:0]              k_reg;
    logic signed [WORD_W-1:0] n_reg [4];
    logic [WORD_W-1:0]       word_reg [4];
    logic                    zflag_reg;
    logic [SQ_W-1:0]         sx_reg, res_reg, bit_reg;
    logic [4:0]              sqrt_cnt_reg;
    logic signed [SQ_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0]        bx_plane_reg, bx_limit_reg;

    logic                    in_accept;
    mode_t                   in_mode;
    logic [SLOT_W-1:0]       in_slot;

    logic                    mat_we, mat_re;
    logic [MAT_AW-1:0]       mat_raddr;
    logic [ROW_W-1:0]        mat_rdata, mat_row;
    logic                    plane_we, plane_re;
    logic [PLANE_AW-1:0]     plane_waddr;
    logic [ROW_W-1:0]        plane_wdata, plane_rdata, plane_row;

    logic                    div_start, div_busy;
    logic [DIV_W-1:0]        div_dividend, div_quotient;
    logic [WORD_W-1:0]       div_mag;
    logic [WORD_W-1:0]       q_clamp;
    logic [WORD_W-1:0]       div_word;

    logic signed [WORD_W-1:0] mul_a, mul_b;
    logic signed [SQ_W-1:0]  mul_p;
    logic signed [WORD_W-1:0] bx_nk, bx_corner;
    logic [SQ_W-1:0]         sqrt_sum;
    logic [CNT_W-1:0]        test_limit;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_mode   = mode_t'(s_axis_tuser);
    assign in_slot   = s_axis_tdata[SLOT_W-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign test_limit = (plane_count_reg > CNT_W'(MAX_PLANES)) ? CNT_W'(MAX_PLANES)
                                                              : plane_count_reg;

    // ---------------- memories ----------------
    assign mat_we    = in_accept && (in_mode == MODE_LOAD_ROW)
                       && (32'(in_slot) < MAT_ROWS);
    assign mat_re    = (state_reg == ST_EX_RD);
    assign mat_raddr = row_cnt_reg;

    fpac_ram #(.WIDTH(ROW_W), .DEPTH(MAT_ROWS)) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (MAT_AW'(in_slot)),
        .wdata (s_axis_tdata[SLOT_W +: ROW_W]),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    assign mat_row = mat_rvalid_reg ? mat_rdata : '0;

    always_comb
    begin
        plane_we    = 1'b0;
        plane_waddr = PLANE_AW'(in_slot);
        plane_wdata = s_axis_tdata[SLOT_W +: ROW_W];
        if (state_reg == ST_EX_WR)
        begin
            plane_we    = 1'b1;
            plane_waddr = PLANE_AW'(plane_idx_reg);
            plane_wdata = {word_reg[3], word_reg[2], word_reg[1], word_reg[0]};
        end
        else if (in_accept && (in_mode == MODE_WRITE_PLANE)
                 && (32'(in_slot) < MAX_PLANES))
        begin
            plane_we = 1'b1;
        end
    end

    assign plane_re = (state_reg == ST_BX_RD);

    fpac_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PLANES)) u_plane_ram (
        .clk   (clk),
        .we    (plane_we),
        .waddr (plane_waddr),
        .wdata (plane_wdata),
        .re    (plane_re),
        .raddr (PLANE_AW'(bx_plane_reg)),
        .rdata (plane_rdata)
    );

    assign plane_row = plane_rvalid_reg ? plane_rdata : '0;

    // ---------------- divider ----------------
    assign div_start    = (state_reg == ST_EX_DIV) && (res_reg != '0);
    assign div_mag      = n_reg[k_reg][WORD_W-1] ? WORD_W'(-n_reg[k_reg])
                                                 : WORD_W'(n_reg[k_reg]);
    assign div_dividend = {div_mag, {FRAC_BITS{1'b0}}};

    fpac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (res_reg[LEN_W-1:0]),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Normals come out negated; the distance keeps its sign.
    always_comb
    begin
        if (div_quotient > DIV_W'({1'b0, {(WORD_W-1){1'b1}}}))
            q_clamp = {1'b0, {(WORD_W-1){1'b1}}};
        else
            q_clamp = div_quotient[WORD_W-1:0];
        if (k_reg != 2'd3)
        begin
            div_word = n_reg[k_reg][WORD_W-1] ? q_clamp : WORD_W'(-q_clamp);
        end
        else if (n_reg[k_reg][WORD_W-1])
        begin
            if (div_quotient >= DIV_W'({1'b1, {(WORD_W-1){1'b0}}}))
                div_word = {1'b1, {(WORD_W-1){1'b0}}};
            else
                div_word = WORD_W'(-div_quotient[WORD_W-1:0]);
        end
        else
        begin
            div_word = q_clamp;
        end
    end

    // ---------------- shared multiplier operands ----------------
    always_comb
    begin
        case (k_reg)
            2'd0:    bx_nk = plane_row[0 +: WORD_W];
            2'd1:    bx_nk = plane_row[WORD_W +: WORD_W];
            default: bx_nk = plane_row[2*WORD_W +: WORD_W];
        endcase
        case (k_reg)
            2'd0:    bx_corner = (bx_nk > 0) ? corner_min_reg[0] : corner_max_reg[0];
            2'd1:    bx_corner = (bx_nk > 0) ? corner_min_reg[1] : corner_max_reg[1];
            default: bx_corner = (bx_nk > 0) ? corner_min_reg[2] : corner_max_reg[2];
        endcase
        if (state_reg == ST_EX_SQ)
        begin
            mul_a = n_reg[k_reg];
            mul_b = n_reg[k_reg];
        end
        else
        begin
            mul_a = bx_nk;
            mul_b = bx_corner;
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign sqrt_sum = res_reg + bit_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_mode)
                        MODE_EXTRACT:  state_next = ST_EX_RD;
                        MODE_TEST_BOX: state_next = (test_limit == '0) ? ST_DONE : ST_BX_RD;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_EX_RD:   state_next = ST_EX_ROW;
            ST_EX_ROW:  state_next = (row_cnt_reg == MAT_AW'(MAT_ROWS - 1)) ? ST_EX_SQ
                                                                            : ST_EX_RD;
            ST_EX_SQ:   state_next = (k_reg == 2'd3) ? ST_EX_SQRT : ST_EX_SQ;
            ST_EX_SQRT: state_next = (sqrt_cnt_reg == '0) ? ST_EX_DIV : ST_EX_SQRT;
            ST_EX_DIV:  state_next = (res_reg == '0) ? ST_EX_WR : ST_EX_DIVW;
            ST_EX_DIVW:
            begin
                if (!div_busy)
                    state_next = (k_reg == 2'd3) ? ST_EX_WR : ST_EX_DIV;
            end
            ST_EX_WR:   state_next = (plane_idx_reg == 3'(EXT_PLANES - 1)) ? ST_DONE
                                                                           : ST_EX_RD;
            ST_BX_RD:   state_next = ST_BX_MUL;
            ST_BX_MUL:  state_next = (k_reg == 2'd3) ? ST_BX_CMP : ST_BX_MUL;
            ST_BX_CMP:
            begin
                if (acc_reg > 0 || (bx_plane_reg + 1'b1) == bx_limit_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_BX_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            plane_count_reg <= PLANE_COUNT_RST;
            out_valid_reg   <= 1'b0;
            mat_valid_reg   <= '0;
            plane_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                plane_count_reg <= cfg_wdata;
            end
            if (mat_we)
            begin
                mat_valid_reg[MAT_AW'(in_slot)] <= 1'b1;
            end
            if (plane_we)
            begin
                plane_valid_reg[plane_waddr] <= 1'b1;
            end
            if (state_reg == ST_DONE && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_culled_reg <= res_culled_reg;
            out_status_reg <= res_status_reg;
        end
        if (mat_re)
        begin
            mat_rvalid_reg <= mat_valid_reg[mat_raddr];
        end
        if (plane_re)
        begin
            plane_rvalid_reg <= plane_valid_reg[PLANE_AW'(bx_plane_reg)];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_culled_reg <= 1'b0;
                    plane_idx_reg  <= '0;
                    row_cnt_reg    <= '0;
                    zflag_reg      <= 1'b0;
                    bx_plane_reg   <= '0;
                    bx_limit_reg   <= test_limit;
                    k_reg          <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        corner_min_reg[i] <= s_axis_tdata[SLOT_W + WORD_W*(4+i) +: WORD_W];
                        corner_max_reg[i] <= s_axis_tdata[SLOT_W + WORD_W*(7+i) +: WORD_W];
                    end
                    if ((in_mode == MODE_LOAD_ROW && 32'(in_slot) >= MAT_ROWS)
                        || (in_mode == MODE_WRITE_PLANE && 32'(in_slot) >= MAX_PLANES))
                    begin
                        res_status_reg <= STAT_BAD_SLOT;
                    end
                    else
                    begin
                        res_status_reg <= STAT_OK;
                    end
                end
            end
            ST_EX_ROW:
            begin
                n_reg[row_cnt_reg] <= sat_pm(mat_row[3*WORD_W +: WORD_W],
                                             mat_row[WORD_W*ext_col(plane_idx_reg) +: WORD_W],
                                             ext_add(plane_idx_reg));
                row_cnt_reg <= row_cnt_reg + 1'b1;
                k_reg       <= '0;
            end
            ST_EX_SQ:
            begin
                // Accumulate the previous square while forming the next one.
                prod_reg <= mul_p;
                if (k_reg == 2'd0)
                    sx_reg <= '0;
                else
                    sx_reg <= sx_reg + SQ_W'(prod_reg);
                if (k_reg == 2'd3)
                begin
                    res_reg      <= '0;
                    bit_reg      <= SQ_W'(1) << (SQ_W - 2);
                    sqrt_cnt_reg <= 5'd31;
                end
                k_reg <= k_reg + 1'b1;
            end
            ST_EX_SQRT:
            begin
                if (sx_reg >= sqrt_sum)
                begin
                    sx_reg  <= sx_reg - sqrt_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg      <= bit_reg >> 2;
                sqrt_cnt_reg <= sqrt_cnt_reg - 1'b1;
                k_reg        <= '0;
            end
            ST_EX_DIV:
            begin
                if (res_reg == '0)
                begin
                    for (int i = 0; i < 4; i++)
                        word_reg[i] <= '0;
                    zflag_reg <= 1'b1;
                end
            end
            ST_EX_DIVW:
            begin
                if (!div_busy)
                begin
                    word_reg[k_reg] <= div_word;
                    k_reg           <= k_reg + 1'b1;
                end
            end
            ST_EX_WR:
            begin
                plane_idx_reg  <= plane_idx_reg + 1'b1;
                row_cnt_reg    <= '0;
                res_status_reg <= zflag_reg ? STAT_ZERO_NORMAL : STAT_OK;
            end
            ST_BX_RD:
            begin
                k_reg <= '0;
            end
            ST_BX_MUL:
            begin
                prod_reg <= mul_p;
                if (k_reg == 2'd0)
                    acc_reg <= -ACC_W'(signed'(plane_row[3*WORD_W +: WORD_W]));
                else
                    acc_reg <= acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
                k_reg <= k_reg + 1'b1;
            end
            ST_BX_CMP:
            begin
                if (acc_reg > 0)
                    res_culled_reg <= 1'b1;
                bx_plane_reg <= bx_plane_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_status_reg, out_culled_reg};

    `FPAC_ASSERT_IMP(a_plane_wr_ctx, clk, rst_n, plane_we, (state_reg == ST_IDLE) || (state_reg == ST_EX_WR))
    `FPAC_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_start, !div_busy)
    `FPAC_ASSERT_NXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `FPAC_ASSERT_IMP(a_culled_ok, clk, rst_n, out_valid_reg && out_culled_reg, out_status_reg == STAT_OK)

endmodule
